/* src/sis_pkg.sv */
// Shared constants and codes for the sorted integer set unit.
package sis_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_TEST   = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

endpackage

/* src/sorted_integer_set_unit.sv */
// Sorted integer set: stream front end, search/insert sequencer and entry store.
//
// Input beat (s_*): s_tuser[1:0] carries the operation (test, insert, clear),
// s_tdata[31:0] the signed key. Output beat (m_*): one beat per input beat with
// is_member, status and count packed into m_tdata.
// Entries live in a single-port store of CAPACITY words with a registered read,
// kept in ascending order with the sign bit flipped so unsigned compare works.
// One item is in work at a time; s_tready is high only while the sequencer idles.
// Steps per item, from acceptance to the result register:
//   clear or unused code: straight to the result
//   test: binary search, each probe a read then compare, then a check read
//   insert: as test, then each entry above the slot moved up (read then write
//   on the one port), then the key written into its slot.
// The store port is the limit: each probe reads it once, each move reads then writes it.
// The result sits in an output register; a stalled receiver holds it there and
// the next item may be accepted, but its result waits until the register frees.
// Reset empties the set (count to zero) and drops any pending result; the store
// contents are not cleared and are never read above the count.
module sorted_integer_set_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sis_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] key
    input  logic [sis_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sis_pkg::M_TDATA_W-1:0]   m_tdata    // [0] is_member, [2:1] status, [9:3] count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_RD,
        S_CHECK_RD,
        S_DECIDE,
        S_SHIFT,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    localparam logic [sis_pkg::CNT_W-1:0] CAP_CNT = sis_pkg::CNT_W'(sis_pkg::CAPACITY);
    localparam logic [sis_pkg::CNT_W-1:0] ONE_CNT = sis_pkg::CNT_W'(1);

    logic [sis_pkg::KEY_W-1:0] mem [sis_pkg::CAPACITY];
    logic [sis_pkg::KEY_W-1:0] mem_rdata_reg;
    logic                      mem_we;
    logic [sis_pkg::ADDR_W-1:0] mem_addr;
    logic [sis_pkg::KEY_W-1:0] mem_wdata;

    state_t                    state_reg, state_next;
    sis_pkg::op_t              op_reg, op_next;
    logic [sis_pkg::KEY_W-1:0] key_reg, key_next;
    logic [sis_pkg::CNT_W-1:0] lo_reg, lo_next;
    logic [sis_pkg::CNT_W-1:0] hi_reg, hi_next;
    logic [sis_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [sis_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      member_reg, member_next;
    sis_pkg::status_t          status_reg, status_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [sis_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [sis_pkg::CNT_W-1:0] mid;
    logic [sis_pkg::CNT_W-1:0] idx_dec;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - ONE_CNT;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        member_next   = member_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_addr      = mid[sis_pkg::ADDR_W-1:0];
        mem_wdata     = mem_rdata_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = sis_pkg::op_t'(s_tuser[sis_pkg::OP_W-1:0]);
                    key_next    = s_tdata[sis_pkg::KEY_W-1:0] ^ sis_pkg::SIGN_FLIP;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    member_next = 1'b0;
                    status_next = sis_pkg::ST_OK;
                    case (sis_pkg::op_t'(s_tuser[sis_pkg::OP_W-1:0]))
                        sis_pkg::OP_TEST,
                        sis_pkg::OP_INSERT: state_next = S_SEARCH;
                        sis_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_addr   = mid[sis_pkg::ADDR_W-1:0];
                    idx_next   = mid;
                    state_next = S_SEARCH_RD;
                end
                else if (lo_reg < count_reg)
                begin
                    mem_addr   = lo_reg[sis_pkg::ADDR_W-1:0];
                    state_next = S_CHECK_RD;
                end
                else
                begin
                    member_next = 1'b0;
                    state_next  = S_DECIDE;
                end
            end
            S_SEARCH_RD:
            begin
                if (mem_rdata_reg < key_reg)
                begin
                    lo_next = idx_reg + ONE_CNT;
                end
                else
                begin
                    hi_next = idx_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK_RD:
            begin
                member_next = (mem_rdata_reg == key_reg);
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
                if (op_reg == sis_pkg::OP_INSERT)
                begin
                    if (count_reg >= CAP_CNT)
                    begin
                        status_next = sis_pkg::ST_FULL;
                    end
                    else if (member_reg)
                    begin
                        status_next = sis_pkg::ST_PRESENT;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (idx_reg > lo_reg)
                begin
                    mem_addr   = idx_dec[sis_pkg::ADDR_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = lo_reg[sis_pkg::ADDR_W-1:0];
                    mem_wdata  = key_reg;
                    count_next = count_reg + ONE_CNT;
                    state_next = S_RESULT;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                mem_addr   = idx_reg[sis_pkg::ADDR_W-1:0];
                mem_wdata  = mem_rdata_reg;
                idx_next   = idx_dec;
                state_next = S_SHIFT;
            end
            S_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = sis_pkg::M_TDATA_W'({
                        sis_pkg::COUNT_OUT_W'(count_reg),
                        status_reg,
                        member_reg
                    });
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= sis_pkg::OP_TEST;
            key_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            idx_reg      <= '0;
            count_reg    <= '0;
            member_reg   <= 1'b0;
            status_reg   <= sis_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            key_reg      <= key_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            member_reg   <= member_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

endmodule

/* src/sis_checker.sv */
// Port-level assertions for the sorted integer set unit, with its bind.
module sis_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sis_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sis_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic [sis_pkg::COUNT_OUT_W-1:0] CAP_OUT =
        sis_pkg::COUNT_OUT_W'(sis_pkg::CAPACITY);

    logic                                is_member;
    logic [sis_pkg::STATUS_W-1:0]        status;
    logic [sis_pkg::COUNT_OUT_W-1:0]     count;

    assign is_member = m_tdata[0];
    assign status    = m_tdata[2:1];
    assign count     = m_tdata[9:3];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> status != sis_pkg::ST_UNUSED)
        else $error("unused status code");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == sis_pkg::ST_FULL |-> count == CAP_OUT)
        else $error("full refusal with count below capacity");

    a_present_member: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == sis_pkg::ST_PRESENT |-> is_member)
        else $error("present refusal without membership");

    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[1:0] == sis_pkg::OP_CLEAR && !m_tvalid
        |=> ##1 m_tvalid && count == '0 && !is_member)
        else $error("clear did not report an empty set");

endmodule

bind sorted_integer_set_unit sis_checker u_sis_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
